[src/svv_pkg.sv]
// svv_pkg: shared types and constants of the sphere volume voxelizer
// command codes, controller state type, command and status bundles
// no dependencies
package svv_pkg;

	// default volume dimensions
	localparam int SVV_SIZE_X = 64;
	localparam int SVV_SIZE_Y = 64;
	localparam int SVV_SIZE_Z = 64;

	// command field widths
	localparam int OP_W    = 2;
	localparam int POS_W   = 6;
	localparam int RAD_W   = 6;
	localparam int GRAY_W  = 8;
	localparam int WALK_W  = RAD_W + 1;
	localparam int COORD_W = RAD_W + 2;
	localparam int R2_W    = 2 * RAD_W;
	localparam int D2_W    = R2_W + 2;

	// command codes
	localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_DRAW,
		ST_DRAIN,
		ST_CLEAR,
		ST_DONE
	} svv_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the incoming command
		logic issue;     // push one voxel point into the pipeline
		logic clr_arm;   // take the fill value for a clear sweep
		logic clr_run;   // write one voxel of the sweep
		logic out_load;  // move the result into the output register
	} svv_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            r_zero;
		logic            walk_last;
		logic            clr_last;
		logic            pipe_busy;
	} svv_sts_t;

endpackage

[src/svv_ram.sv]
// svv_ram: generic single-port ram with registered read
// depends on nothing
module svv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[src/svv_ctrl.sv]
// svv_ctrl: command sequencer of the voxelizer
// depends on svv_pkg, drives the svv_datapath through svv_cmd_t / svv_sts_t
module svv_ctrl
	import svv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	output logic     s_ready,
	output logic     m_valid,
	input  logic     m_ready,
	output svv_cmd_t cmd,
	input  svv_sts_t sts
);

	svv_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					OP_DRAW: begin
						state_d = sts.r_zero ? ST_DONE : ST_DRAW;
					end
					OP_READ: begin
						cmd.issue = 1'b1;
						state_d   = ST_DRAIN;
					end
					OP_CLEAR: begin
						cmd.clr_arm = 1'b1;
						state_d     = ST_CLEAR;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_DRAW: begin
				cmd.issue = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// the sweep owns the ram port, so no walk point may be in flight
	a_sweep_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_run |-> (!cmd.issue && !sts.pipe_busy))
		else $error("clear sweep overlaps pipelined access");

	// a result is only produced once the pipeline has fully drained
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !sts.pipe_busy)
		else $error("result produced with pipeline still busy");

	// the last point of a walk always leads to the drain
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW && sts.walk_last) |=> (state_q == ST_DRAIN))
		else $error("walk did not end after its last point");

endmodule

[src/svv_datapath.sv]
// svv_datapath: sphere walk counters, distance and address pipeline, voxel ram
// depends on svv_pkg and svv_ram, controlled by svv_ctrl
module svv_datapath
	import svv_pkg::*;
#(
	parameter int SIZE_X = SVV_SIZE_X,
	parameter int SIZE_Y = SVV_SIZE_Y,
	parameter int SIZE_Z = SVV_SIZE_Z
) (
	input  logic              clk,
	input  logic              arst_n,
	input  svv_cmd_t          cmd,
	output svv_sts_t          sts,
	input  logic [OP_W-1:0]   op,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [POS_W-1:0]  pos_z,
	input  logic [RAD_W-1:0]  radius,
	input  logic [GRAY_W-1:0] gray_value,
	input  logic              cfg_we,
	input  logic [GRAY_W-1:0] cfg_wdata,
	output logic [GRAY_W-1:0] voxel_value,
	output logic [OP_W-1:0]   done_op
);

	localparam int VOL = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW  = $clog2(VOL);
	localparam logic [AW-1:0] PLANE    = AW'(SIZE_X * SIZE_Y);
	localparam logic [AW-1:0] ROW      = AW'(SIZE_X);
	localparam logic [AW-1:0] LAST_ADR = AW'(VOL - 1);

	// latched command
	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  cx_q, cy_q, cz_q;
	logic [RAD_W-1:0]  r_q;
	logic [GRAY_W-1:0] gray_q;
	logic [R2_W-1:0]   r2_q;

	logic [WALK_W-1:0] wx_q, wy_q, wz_q;
	logic [WALK_W-1:0] span_m1;
	logic              is_draw;

	logic signed [COORD_W-1:0]   ox, oy, oz;
	logic signed [COORD_W-1:0]   xc, yc, zc;
	logic signed [2*COORD_W-1:0] sq_x, sq_y, sq_z;

	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [D2_W-1:0]           d2_s1;
	logic                      vld_s1, rdop_s1;

	logic          ok_s1, hit_s1;
	logic [AW-1:0] addr_s2;
	logic          we_s2, rd_s2, rdv_s3;

	logic [GRAY_W-1:0] value_q, ram_rdata;
	logic [AW-1:0]     clr_addr_q;
	logic [GRAY_W-1:0] clr_val_q, fill_q;
	logic [GRAY_W-1:0] out_val_q;
	logic [OP_W-1:0]   out_op_q;

	logic          ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [GRAY_W-1:0] ram_wdata;

	assign is_draw = (op_q == OP_DRAW);
	assign span_m1 = {r_q, 1'b0} - WALK_W'(1);

	// offsets from the center, zero for a single-voxel read
	assign ox = is_draw ? $signed({1'b0, wx_q}) - $signed({2'b0, r_q}) : '0;
	assign oy = is_draw ? $signed({1'b0, wy_q}) - $signed({2'b0, r_q}) : '0;
	assign oz = is_draw ? $signed({1'b0, wz_q}) - $signed({2'b0, r_q}) : '0;

	assign xc = $signed({2'b0, cx_q}) + ox;
	assign yc = $signed({2'b0, cy_q}) + oy;
	assign zc = $signed({2'b0, cz_q}) + oz;

	assign sq_x = ox * ox;
	assign sq_y = oy * oy;
	assign sq_z = oz * oz;

	// stage 2 decode: clip against the volume, sphere membership
	assign ok_s1 = !x_s1[COORD_W-1] && ({1'b0, x_s1} < (COORD_W+1)'(SIZE_X))
		&& !y_s1[COORD_W-1] && ({1'b0, y_s1} < (COORD_W+1)'(SIZE_Y))
		&& !z_s1[COORD_W-1] && ({1'b0, z_s1} < (COORD_W+1)'(SIZE_Z));
	assign hit_s1 = d2_s1 < {2'b0, r2_q};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			we_s2      <= 1'b0;
			rd_s2      <= 1'b0;
			rdv_s3     <= 1'b0;
			clr_addr_q <= '0;
			clr_val_q  <= '0;
			fill_q     <= '0;
		end else begin
			vld_s1 <= cmd.issue;
			we_s2  <= vld_s1 && ok_s1 && !rdop_s1 && hit_s1;
			rd_s2  <= vld_s1 && ok_s1 && rdop_s1;
			rdv_s3 <= rd_s2;
			if (cfg_we) begin
				fill_q <= cfg_wdata;
			end
			if (cmd.clr_arm) begin
				clr_val_q <= fill_q;
			end
			if (cmd.clr_run) begin
				clr_addr_q <= (clr_addr_q == LAST_ADR) ? '0 : clr_addr_q + AW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		r2_q <= R2_W'(r_q) * R2_W'(r_q);
		if (cmd.load) begin
			op_q    <= op;
			cx_q    <= pos_x;
			cy_q    <= pos_y;
			cz_q    <= pos_z;
			r_q     <= radius;
			gray_q  <= gray_value;
			wx_q    <= '0;
			wy_q    <= '0;
			wz_q    <= '0;
			value_q <= '0;
		end else begin
			if (cmd.issue && is_draw) begin
				if (wx_q == span_m1) begin
					wx_q <= '0;
					if (wy_q == span_m1) begin
						wy_q <= '0;
						wz_q <= wz_q + WALK_W'(1);
					end else begin
						wy_q <= wy_q + WALK_W'(1);
					end
				end else begin
					wx_q <= wx_q + WALK_W'(1);
				end
			end
			if (rdv_s3) begin
				value_q <= ram_rdata;
			end
		end
		x_s1    <= xc;
		y_s1    <= yc;
		z_s1    <= zc;
		rdop_s1 <= !is_draw;
		d2_s1   <= D2_W'(sq_x[R2_W-1:0]) + D2_W'(sq_y[R2_W-1:0])
			+ D2_W'(sq_z[R2_W-1:0]);
		addr_s2 <= PLANE * AW'(z_s1[COORD_W-2:0]) + ROW * AW'(y_s1[COORD_W-2:0])
			+ AW'(x_s1[COORD_W-2:0]);
		if (cmd.out_load) begin
			out_val_q <= value_q;
			out_op_q  <= op_q;
		end
	end

	assign ram_en    = cmd.clr_run || we_s2 || rd_s2;
	assign ram_we    = cmd.clr_run || we_s2;
	assign ram_addr  = cmd.clr_run ? clr_addr_q : addr_s2;
	assign ram_wdata = cmd.clr_run ? clr_val_q : gray_q;

	svv_ram #(
		.WIDTH(GRAY_W),
		.DEPTH(VOL)
	) u_volume (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign sts.op        = op_q;
	assign sts.r_zero    = (r_q == '0);
	assign sts.walk_last = (wx_q == span_m1) && (wy_q == span_m1) && (wz_q == span_m1);
	assign sts.clr_last  = (clr_addr_q == LAST_ADR);
	assign sts.pipe_busy = vld_s1 || we_s2 || rd_s2 || rdv_s3;

	assign voxel_value = out_val_q;
	assign done_op     = out_op_q;

endmodule

[src/sphere_volume_voxelizer_top.sv]
// sphere_volume_voxelizer_top: top level of the gray-level sphere voxelizer
// depends on svv_pkg, svv_ctrl, svv_datapath and svv_ram
//
// slave stream: one command per beat; tuser carries the command code (draw
//   sphere, read voxel, clear volume), tdata the position, radius and gray level
// master stream: one result beat per command; tdata is the voxel read (zero for
//   other commands), tuser echoes the command code
// cfg_we / cfg_wdata write the fill value used by clear; write it only while no
//   command is in flight
// timing: one command at a time; s_axis_tready is high only when idle
//   read: one point through the distance / address pipeline and a ram read
//   draw: (2*radius)^3 walk points, one per cycle through the distance /
//   address pipeline, then a drain; radius 0 and the unused code skip the walk
//   clear: all SIZE_X*SIZE_Y*SIZE_Z voxels, one ram write per cycle
// reset: arst_n starts a zeroing sweep of all SIZE_X*SIZE_Y*SIZE_Z voxels (262144
//   at the default size) during which no command is taken; config is accepted
// stalls: a finished result sits in the output register until m_axis_tready;
//   the next command is accepted meanwhile and waits only at its own end
module sphere_volume_voxelizer_top
	import svv_pkg::*;
#(
	parameter int SIZE_X = SVV_SIZE_X,
	parameter int SIZE_Y = SVV_SIZE_Y,
	parameter int SIZE_Z = SVV_SIZE_Z
) (
	input  logic              clk,
	input  logic              arst_n,
	// command stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,   // pos_x, pos_y, pos_z, radius, gray_value
	input  logic [OP_W-1:0]   s_axis_tuser,   // op
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // voxel_value
	output logic [OP_W-1:0]   m_axis_tuser,   // done_op
	// fill value register
	input  logic              cfg_we,
	input  logic [GRAY_W-1:0] cfg_wdata
);

	svv_cmd_t cmd;
	svv_sts_t sts;

	svv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.cmd    (cmd),
		.sts    (sts)
	);

	// tdata unpacking, lowest field first
	svv_datapath #(
		.SIZE_X(SIZE_X),
		.SIZE_Y(SIZE_Y),
		.SIZE_Z(SIZE_Z)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (s_axis_tuser),
		.pos_x      (s_axis_tdata[5:0]),
		.pos_y      (s_axis_tdata[11:6]),
		.pos_z      (s_axis_tdata[17:12]),
		.radius     (s_axis_tdata[23:18]),
		.gray_value (s_axis_tdata[31:24]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.voxel_value(m_axis_tdata),
		.done_op    (m_axis_tuser)
	);

endmodule
